FILE: rtl/core/nla_pkg.sv
// Shared types and constants of the newline line assembler.
package nla_pkg;

	localparam int LINE_SIZE_DEF = 64;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 6;
	localparam int CFG_W = 7;
	localparam int TDATA_W = 16;
	localparam logic [CFG_W-1:0] MAX_LEN_RST = 7'd64;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_LF   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [BYTE_W-1:0] data;
	} item_t;

endpackage

FILE: rtl/core/newline_line_assembler_unit.sv
// Top level of the newline line assembler.
//
// Channel   Direction  Signals                      Contents
// s_*       in         tvalid tready tdata[7:0]     rx_byte
// m_*       out        tvalid tready tdata[15:0]    line_byte, line_length, zero pad
//                      tuser tlast                  empty_line, last_of_line
// cfg_*     in         valid ready data[6:0]        max_line_len
//
// Ordinary bytes and carriage returns are accepted at one per cycle while the queue has room.
// A line feed holds the work side while its line is played out, one output word per byte and
// at least one; the two-entry queue keeps accepting input meanwhile until it fills.
// The output register holds one word, so a stalled m_tready stops the run only.
// Reset clears the byte count and sets max_line_len to 64; the store is not cleared.
module newline_line_assembler_unit #(
	parameter int LINE_SIZE = nla_pkg::LINE_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [nla_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [nla_pkg::TDATA_W-1:0] m_tdata,  // [7:0] line_byte, [13:8] line_length
	output logic m_tuser,                         // [0] empty_line
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [nla_pkg::CFG_W-1:0] cfg_data
);
	import nla_pkg::*;

	logic q_valid;
	item_t q_item;
	logic pop;

	assign cfg_ready = 1'b1;

	nla_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.q_valid(q_valid),
		.q_item(q_item),
		.pop(pop)
	);

	nla_back #(
		.LINE_SIZE(LINE_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.pop(pop),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

FILE: rtl/core/nla_front.sv
// Input side: drops carriage returns, tags line feeds and queues the words.
module nla_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [nla_pkg::BYTE_W-1:0] s_tdata,
	output logic q_valid,
	output nla_pkg::item_t q_item,
	input  logic pop
);
	import nla_pkg::*;

	item_t q_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	item_t new_item;

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready && (s_tdata != CHAR_CR);
	assign new_item.kind = (s_tdata == CHAR_LF) ? KIND_LF : KIND_DATA;
	assign new_item.data = s_tdata;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != 2'd0)
		else $error("pop from empty queue");
	a_cr_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata == CHAR_CR && !pop) |=> $stable(cnt_q))
		else $error("carriage return entered the queue");

endmodule

FILE: rtl/core/nla_back.sv
// Work side: stores line bytes and plays a finished line out as a run of words.
module nla_back #(
	parameter int LINE_SIZE = nla_pkg::LINE_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  nla_pkg::item_t q_item,
	output logic pop,
	input  logic cfg_valid,
	input  logic [nla_pkg::CFG_W-1:0] cfg_data,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [nla_pkg::TDATA_W-1:0] m_tdata,
	output logic m_tuser,
	output logic m_tlast
);
	import nla_pkg::*;

	localparam int CW = $clog2(LINE_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic [BYTE_W-1:0] mem [LINE_SIZE];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] k_q;
	logic [CFG_W-1:0] max_len_q;
	logic out_valid_q;
	logic out_last_q;
	logic out_empty_q;
	logic [CW-1:0] out_len_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CFG_W-1:0] limit;
	logic [CFG_W-1:0] cnt_ext;
	logic [CFG_W-1:0] len_ext;
	logic load;
	logic wr;
	logic is_empty;
	logic is_last;

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign wr = pop && (q_item.kind == KIND_DATA) && (cnt_q < CW'(LINE_SIZE - 1));
	assign limit = (max_len_q == '0) ? CFG_W'(1) : max_len_q;
	assign cnt_ext = CFG_W'(cnt_q);
	assign len_ext = (cnt_ext >= limit) ? (limit - CFG_W'(1)) : cnt_ext;
	assign load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign is_empty = (len_q == '0);
	assign is_last = is_empty || (k_q == len_q - CW'(1));

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(TDATA_W - BYTE_W - LEN_W){1'b0}}, LEN_W'(out_len_q), out_byte_q};
	assign m_tuser = out_empty_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[cnt_q] <= q_item.data;
		end
		if (load) begin
			out_byte_q <= is_empty ? '0 : mem[k_q];
			out_len_q <= len_q;
			out_empty_q <= is_empty;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			len_q <= '0;
			k_q <= '0;
			max_len_q <= MAX_LEN_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_item.kind == KIND_LF) begin
							len_q <= len_ext[CW-1:0];
							k_q <= '0;
							cnt_q <= '0;
							state_q <= ST_EMIT;
						end else if (wr) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							cnt_q <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						k_q <= k_q + CW'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !pop)
		else $error("queue popped during line output");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LINE_SIZE - 1))
		else $error("line store count overflow");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> out_last_q)
		else $error("empty line word without last mark");

endmodule

FILE: tb/newline_line_assembler_unit_test.sv
// Self-checking testbench of the newline line assembler with a line scoreboard.
`timescale 1ns / 100ps

module newline_line_assembler_unit_test;
	import nla_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 32;

	typedef struct {
		logic [BYTE_W-1:0] line_byte;
		logic [LEN_W-1:0] line_length;
		logic empty_line;
		logic last_of_line;
	} line_word_t;

	class line_scoreboard;
		logic [BYTE_W-1:0] held_bytes [LINE_SIZE_DEF];
		int held;
		int buf_size;
		line_word_t expected_words [$];
		int errors;
		int bytes_seen;
		int lines_seen;
		int words_checked;

		function void reset_state();
			held = 0;
			buf_size = int'(MAX_LEN_RST);
			expected_words.delete();
		endfunction

		function void set_buffer_size(logic [CFG_W-1:0] value);
			buf_size = int'(value);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b);
			int limit;
			int len;
			line_word_t w;
			if (b == CHAR_CR)
				return;
			bytes_seen++;
			if (b != CHAR_LF) begin
				if (held < LINE_SIZE_DEF - 1) begin
					held_bytes[held] = b;
					held++;
				end else begin
					held = 0;
				end
				return;
			end
			lines_seen++;
			limit = (buf_size == 0) ? 1 : buf_size;
			len = held;
			if (len >= limit)
				len = limit - 1;
			if (len > 63)
				len = 63;
			held = 0;
			if (len == 0) begin
				w.line_byte = '0;
				w.line_length = '0;
				w.empty_line = 1'b1;
				w.last_of_line = 1'b1;
				expected_words.push_back(w);
				return;
			end
			for (int k = 0; k < len; k++) begin
				w.line_byte = held_bytes[k];
				w.line_length = len[LEN_W-1:0];
				w.empty_line = 1'b0;
				w.last_of_line = (k + 1 == len);
				expected_words.push_back(w);
			end
		endfunction

		function void check_word(logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l, logic e, logic t);
			line_word_t w;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none,", $time,
					" actual byte=%0h len=%0d empty=%0b last=%0b", d, l, e, t);
				return;
			end
			w = expected_words.pop_front();
			words_checked++;
			if (d !== w.line_byte) begin
				errors++;
				$display("%0t: line_byte expected %0h actual %0h", $time, w.line_byte, d);
			end
			if (l !== w.line_length) begin
				errors++;
				$display("%0t: line_length expected %0d actual %0d", $time, w.line_length, l);
			end
			if (e !== w.empty_line) begin
				errors++;
				$display("%0t: empty_line expected %0b actual %0b", $time, w.empty_line, e);
			end
			if (t !== w.last_of_line) begin
				errors++;
				$display("%0t: last_of_line expected %0b actual %0b", $time, w.last_of_line, t);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	line_scoreboard sb;
	bit tx_idle;
	bit rx_idle;
	bit reset_done;
	int cycle_count;
	int sizes_used;

	newline_line_assembler_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] line_char();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == CHAR_LF);
		return b;
	endfunction

	task automatic send_byte(logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_byte(b);
	endtask

	task automatic send_line(int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_byte(CHAR_CR);
			send_byte(line_char());
		end
		if ($urandom_range(0, 3) == 0)
			send_byte(CHAR_CR);
		send_byte(CHAR_LF);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_buffer_size(logic [CFG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		sb.set_buffer_size(value);
		sizes_used++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int gap;
		wait (reset_done);
		forever begin
			gap = rx_idle ? $urandom_range(0, 9) : 0;
			repeat (gap) begin
				@(negedge clk);
				m_tready = 1'b0;
			end
			@(negedge clk);
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (m_tvalid !== 1'b1);
			sb.check_word(m_tdata[7:0], m_tdata[13:8], m_tuser, m_tlast);
		end
	end

	initial begin
		logic [BYTE_W-1:0] opening [13];
		int p;
		int n;
		logic [CFG_W-1:0] size;
		opening = '{8'h00, 8'hFF, CHAR_CR, 8'h41, CHAR_LF, CHAR_LF,
			CHAR_CR, CHAR_LF, 8'h80, 8'h7F, CHAR_CR, 8'h55, CHAR_LF};
		sb = new();
		sb.reset_state();
		cycle_count = 0;
		sizes_used = 1;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		reset_done = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		reset_done = 1'b1;

		foreach (opening[i])
			send_byte(opening[i]);
		write_buffer_size(7'd1);
		send_byte(8'h33);
		send_byte(CHAR_LF);
		write_buffer_size(7'd0);
		send_byte(8'hAA);
		send_byte(CHAR_LF);
		send_byte(CHAR_LF);

		p = 0;
		while (p < 7 || sb.bytes_seen < 210 || sb.words_checked + sb.pending() < 48) begin
			case (p % 7)
				0: size = 7'd64;
				1: size = 7'd127;
				2: size = 7'd2;
				3: size = CFG_W'($urandom_range(3, 62));
				4: size = 7'd63;
				5: size = CFG_W'($urandom_range(65, 126));
				default: size = 7'd1;
			endcase
			write_buffer_size(size);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if (p == 0) begin
				send_line(63);
				send_line(65);
			end
			n = sb.bytes_seen + 6;
			while (sb.bytes_seen < n) begin
				if ($urandom_range(0, 7) == 0)
					send_byte(BYTE_W'($urandom_range(0, 255)));
				else
					send_line($urandom_range(0, 10));
			end
			p++;
		end

		wait_idle();
		if (sb.pending() != 0)
			sb.errors++;
		$display("Sent %0d bytes forming %0d lines under %0d buffer sizes.",
			sb.bytes_seen, sb.lines_seen, sizes_used);
		$display("Checked %0d output words, %0d mismatches.", sb.words_checked, sb.errors);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
